@@ design/ake_pkg.sv @@
// Shared types, constants and round functions for the AES-128 key expansion block.
package ake_pkg;

  localparam int unsigned KeyWidth      = 128;
  localparam int unsigned HalfWidth     = 64;
  localparam int unsigned RoundWidth    = 4;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [RoundWidth-1:0] FirstRound = 4'd0;
  localparam logic [RoundWidth-1:0] LastRound  = 4'd10;

  typedef struct packed {
    logic [HalfWidth-1:0] key_hi;
    logic [HalfWidth-1:0] key_lo;
  } key_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } key_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant used to build the key of round cur_round + 1.
  function automatic logic [7:0] rcon(input logic [RoundWidth-1:0] cur_round);
    logic [7:0] rc;
    unique case (cur_round)
      4'd0:    rc = 8'h01;
      4'd1:    rc = 8'h02;
      4'd2:    rc = 8'h04;
      4'd3:    rc = 8'h08;
      4'd4:    rc = 8'h10;
      4'd5:    rc = 8'h20;
      4'd6:    rc = 8'h40;
      4'd7:    rc = 8'h80;
      4'd8:    rc = 8'h1b;
      4'd9:    rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic key_t next_round_key(input key_t cur, input logic [RoundWidth-1:0] cur_round);
    logic [31:0] w0, w1, w2, w3, rot, sub, n0, n1, n2, n3;
    key_t nk;
    w0  = cur.key_hi[63:32];
    w1  = cur.key_hi[31:0];
    w2  = cur.key_lo[63:32];
    w3  = cur.key_lo[31:0];
    rot = {w3[23:0], w3[31:24]};
    sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
    n0  = w0 ^ sub ^ {rcon(cur_round), 24'h000000};
    n1  = w1 ^ n0;
    n2  = w2 ^ n1;
    n3  = w3 ^ n2;
    nk.key_hi = {n0, n1};
    nk.key_lo = {n2, n3};
    return nk;
  endfunction

endpackage

@@ design/ake_key_fifo.sv @@
// Front end: accepts cipher keys and holds them in a short queue for the round engine.
module ake_key_fifo #(
  parameter int unsigned QueueDepth = ake_pkg::QueueDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ake_pkg::key_t   in_key,
  output ake_pkg::key_req_t req,
  input  logic            req_ready
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);
  localparam logic [PtrWidth-1:0] PtrMax   = PtrWidth'(QueueDepth - 1);
  localparam logic [CntWidth-1:0] CntFull  = CntWidth'(QueueDepth);

  ake_pkg::key_t       mem_r [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrWidth-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntWidth-1:0] count_r, count_nxt;
  logic                push, pop;

  assign in_ready  = (count_r != CntFull);
  assign push      = in_valid && in_ready;
  assign req.valid = (count_r != '0);
  assign req.key   = mem_r[rd_ptr_r];
  assign pop       = req.valid && req_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_key;
    end
  end

endmodule

@@ design/ake_round_engine.sv @@
// Back end: while out_ready is high, expands one key a round per cycle straight into the output register.
module ake_round_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ake_pkg::key_req_t              req,
  output logic                           req_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ake_pkg::key_t                  out_key,
  output logic [ake_pkg::RoundWidth-1:0] out_round,
  output logic                           out_last
);

  logic                           valid_r, valid_nxt;
  logic [ake_pkg::RoundWidth-1:0] round_r, round_nxt;
  ake_pkg::key_t                  key_r, key_nxt;
  logic                           is_last, slot_free;

  assign is_last   = (round_r == ake_pkg::LastRound);
  assign slot_free = !valid_r || (out_ready && is_last);
  assign req_ready = slot_free;

  always_comb begin
    valid_nxt = valid_r;
    round_nxt = round_r;
    key_nxt   = key_r;
    if (valid_r && out_ready && !is_last) begin
      round_nxt = round_r + 1'b1;
      key_nxt   = ake_pkg::next_round_key(key_r, round_r);
    end else if (slot_free) begin
      valid_nxt = req.valid;
      round_nxt = ake_pkg::FirstRound;
      key_nxt   = req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      round_r <= ake_pkg::FirstRound;
    end else begin
      valid_r <= valid_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign out_valid = valid_r;
  assign out_key   = key_r;
  assign out_round = round_r;
  assign out_last  = valid_r && is_last;

endmodule

@@ design/aes128_key_expansion_top.sv @@
// Top level of the AES-128 key expansion block.
// Usage: each transaction on the in_ stream carries one 128-bit cipher key
// (in_tdata[63:0] holds key bytes 0 to 7, in_tdata[127:64] bytes 8 to 15).
// For every key the out_ stream delivers eleven round keys in order, round 0
// to round 10; out_tuser gives the round number and out_tlast marks round 10.
// When the block is empty, an accepted key is written into the FIFO and then
// loaded into the engine's output register as round 0. The round engine
// produces one round key per cycle while out_tready is high, so the
// throughput is set by the single round unit feeding one output register.
// Keys are queued in a small FIFO (QueueDepth entries), so new keys are
// taken while results are still being delivered.
// When the receiver holds out_tready low the current round key stays on the
// output and expansion pauses; the FIFO keeps accepting until it is full.
// Reset (rst_n low, synchronous) empties the queue and drops any key in
// progress; nothing is carried from one key to the next.
module aes128_key_expansion_top #(
  parameter int unsigned QueueDepth = ake_pkg::QueueDepthDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] key_hi, [127:64] key_lo
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] round_key_hi, [127:64] round_key_lo
  output logic [3:0]   out_tuser,  // [3:0] round_number
  output logic         out_tlast
);

  ake_pkg::key_t     in_key, out_key;
  ake_pkg::key_req_t req;
  logic              req_ready;

  assign in_key.key_hi = in_tdata[63:0];
  assign in_key.key_lo = in_tdata[127:64];

  ake_key_fifo #(
    .QueueDepth(QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_key   (in_key),
    .req      (req),
    .req_ready(req_ready)
  );

  ake_round_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .req_ready(req_ready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_key  (out_key),
    .out_round(out_tuser),
    .out_last (out_tlast)
  );

  assign out_tdata = {out_key.key_lo, out_key.key_hi};

`ifndef SYNTHESIS
  a_last_on_final_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == ake_pkg::LastRound)))
    else $error("out_tlast does not match the final round");

  a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= ake_pkg::LastRound))
    else $error("round number out of range");

  a_rounds_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tuser == $past(out_tuser) + 4'd1)))
    else $error("round keys not delivered consecutively");

  a_new_key_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (!out_tvalid || (out_tuser == ake_pkg::FirstRound)))
    else $error("new key does not start at round 0");
`endif

endmodule
